// ===== design/cpa_pkg.sv =====
`timescale 1ns / 1ps

package cpa_pkg;

   localparam int MAX_PAGES_DEF  = 1024;
   localparam int PAGE_SHIFT_DEF = 12;

   localparam int POOL_W   = 11;
   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 23;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 12;
   localparam int CSR_IDX_W = 1;

   // Map entry codes: zero marks a free page, all ones a continuation page
   localparam logic [ENTRY_W-1:0] ENTRY_FREE = '0;
   localparam logic [ENTRY_W-1:0] ENTRY_CONT = '1;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_PAGES   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 1'd1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_CHK,
      S_WRITE,
      S_DONE
   } engine_state_type;

   typedef struct packed {
      logic [POOL_W-1:0] pool_pages;
      logic [ADDR_W-1:0] base_address;
   } cfg_type;

   typedef struct packed {
      logic              opcode;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0] free_address;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted_address;
   } result_type;

endpackage

// ===== design/cpa_ram.sv =====
`timescale 1ns / 1ps

module cpa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cpa_engine.sv =====
`timescale 1ns / 1ps

module cpa_engine
   import cpa_pkg::*;
#(
   parameter int MAX_PAGES  = MAX_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       clear_req,
   input  logic       item_valid,
   output logic       item_ready,
   input  item_type   item,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int NW = BYTES_W + 1 - PAGE_SHIFT;
   localparam int LW = (CW > ENTRY_W) ? CW : ENTRY_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_PAGES - 1);

   engine_state_type state_ff, state_in;

   logic [NW-1:0]       need_ff, need_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       iss_ff, iss_in;
   logic                iss_on_ff, iss_on_in;
   logic                chk_valid_ff, chk_valid_in;
   logic [AW-1:0]       chk_idx_ff, chk_idx_in;
   logic [AW-1:0]       wr_idx_ff, wr_idx_in;
   logic [LW-1:0]       left_ff, left_in;
   logic                first_ff, first_in;
   logic [ENTRY_W-1:0]  head_val_ff, head_val_in;
   logic [ENTRY_W-1:0]  fill_ff, fill_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ADDR_W-1:0]   grant_ff, grant_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;

   logic [CW-1:0]     live_pages;
   logic [BYTES_W:0]  round_sum;
   logic [NW-1:0]     need_w;
   logic              alloc_fail;
   logic [ADDR_W-1:0] free_off;
   logic [ADDR_W-1:0] free_idx;
   logic              free_in_pool;
   logic              accept;
   logic [CW-1:0]     cnt_next;
   logic              scan_hit;
   logic              scan_end;
   logic              free_bad;
   logic              write_last;

   cpa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_PAGES),
      .AW   (AW)
   ) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // Pool clipped to the map depth
   assign live_pages = (32'(cfg.pool_pages) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                               : CW'(cfg.pool_pages);

   assign round_sum  = {1'b0, item.request_bytes} + (BYTES_W+1)'((1 << PAGE_SHIFT) - 1);
   assign need_w     = round_sum[BYTES_W:PAGE_SHIFT];
   assign alloc_fail = (need_w == '0) || (live_pages == '0)
                       || (32'(need_w) > 32'(live_pages));

   assign free_off     = item.free_address - cfg.base_address;
   assign free_idx     = free_off >> PAGE_SHIFT;
   assign free_in_pool = free_idx < 32'(live_pages);

   assign accept   = item_valid && item_ready;
   assign cnt_next = cnt_ff + CW'(1);
   assign scan_hit = chk_valid_ff && (ram_rdata == ENTRY_FREE)
                     && (32'(cnt_next) == 32'(need_ff));
   assign scan_end = chk_valid_ff && !scan_hit && (chk_idx_ff == '0);
   assign free_bad = (ram_rdata == ENTRY_FREE) || (ram_rdata == ENTRY_CONT);
   assign write_last = (left_ff == LW'(1))
                       || ((32'(wr_idx_ff) + 32'd1) >= 32'(live_pages));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (wr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (item.opcode == OP_ALLOC) begin
                  state_in = alloc_fail ? S_DONE : S_SCAN;
               end else begin
                  state_in = free_in_pool ? S_FREE_CHK : S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               state_in = S_WRITE;
            end else if (scan_end) begin
               state_in = S_DONE;
            end
         end
         S_FREE_CHK: begin
            state_in = free_bad ? S_DONE : S_WRITE;
         end
         S_WRITE: begin
            if (write_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
      if (clear_req) begin
         state_in = S_CLEAR;
      end
   end

   // Outputs and memory control
   always_comb begin
      item_ready = 1'b0;
      res_valid  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = wr_idx_ff;
      ram_wdata  = ENTRY_FREE;
      ram_re     = 1'b0;
      ram_raddr  = iss_ff;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_IDLE: begin
            item_ready = 1'b1;
            ram_re     = item_valid && (item.opcode == OP_FREE);
            ram_raddr  = AW'(free_idx);
         end
         S_SCAN: begin
            ram_re = iss_on_ff && !scan_hit;
         end
         S_FREE_CHK: begin
         end
         S_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = first_ff ? head_val_ff : fill_ff;
         end
         S_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath
   always_comb begin
      need_in      = need_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      iss_on_in    = iss_on_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      wr_idx_in    = wr_idx_ff;
      left_in      = left_ff;
      first_in     = first_ff;
      head_val_in  = head_val_ff;
      fill_in      = fill_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      case (state_ff)
         S_CLEAR: begin
            wr_idx_in = wr_idx_ff + AW'(1);
         end
         S_IDLE: begin
            need_in   = need_w;
            cnt_in    = '0;
            iss_in    = AW'(live_pages - CW'(1));
            iss_on_in = 1'b1;
            wr_idx_in = AW'(free_idx);
            grant_in  = '0;
            if (item.opcode == OP_ALLOC) begin
               status_in = ST_ALLOC_FAIL;
            end else begin
               status_in = ST_BAD_FREE;
            end
         end
         S_SCAN: begin
            if (iss_on_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = iss_ff;
               iss_in       = iss_ff - AW'(1);
               iss_on_in    = (iss_ff != '0);
            end
            if (chk_valid_ff) begin
               cnt_in = (ram_rdata == ENTRY_FREE) ? cnt_next : '0;
            end
            if (scan_hit) begin
               chk_valid_in = 1'b0;
               wr_idx_in    = chk_idx_ff;
               left_in      = LW'(need_ff);
               first_in     = 1'b1;
               head_val_in  = ENTRY_W'(need_ff) & ENTRY_CONT;
               fill_in      = ENTRY_CONT;
               status_in    = ST_OK;
               grant_in     = cfg.base_address + (32'(chk_idx_ff) << PAGE_SHIFT);
            end
         end
         S_FREE_CHK: begin
            left_in     = LW'(ram_rdata);
            first_in    = 1'b1;
            head_val_in = ENTRY_FREE;
            fill_in     = ENTRY_FREE;
            if (!free_bad) begin
               status_in = ST_OK;
            end
         end
         S_WRITE: begin
            wr_idx_in = wr_idx_ff + AW'(1);
            left_in   = left_ff - LW'(1);
            first_in  = 1'b0;
         end
         default: begin
         end
      endcase
      if (clear_req) begin
         wr_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wr_idx_ff    <= '0;
         iss_on_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_idx_ff    <= wr_idx_in;
         iss_on_ff    <= iss_on_in;
         chk_valid_ff <= chk_valid_in;
      end
      need_ff     <= need_in;
      cnt_ff      <= cnt_in;
      iss_ff      <= iss_in;
      chk_idx_ff  <= chk_idx_in;
      left_ff     <= left_in;
      first_ff    <= first_in;
      head_val_ff <= head_val_in;
      fill_ff     <= fill_in;
      status_ff   <= status_in;
      grant_ff    <= grant_in;
   end

   assign res.status          = status_ff;
   assign res.granted_address = grant_ff;

endmodule

// ===== design/contiguous_page_allocator.sv =====
`timescale 1ns / 1ps

// First-fit contiguous page allocator.
// req channel: one transaction per request. tuser carries the opcode (allocate or
// free); tdata carries the byte count and the address to release.
// rsp channel: exactly one transaction per request, in request order; tuser is the
// status, tdata the granted address (zero on failure and on every free).
// csr channel: index 0 writes the pool size in pages and clears the map, index 1
// writes the base address. Write only while no request is in flight.
// Timing: an allocate scans the page map one entry a cycle from the top of the
// pool down, through the single read port of the map memory, then writes the run
// one entry a cycle. A free clears its run in the same way.
// Reset and every pool size write start a clearing pass over all MAX_PAGES map entries,
// during which no request is taken; configuration writes are still accepted.
// A finished result waits in the output register, so the next request is taken
// while the receiver stalls; the engine holds its next result until it drains.
module contiguous_page_allocator
   import cpa_pkg::*;
#(
   parameter int MAX_PAGES  = MAX_PAGES_DEF,
   parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [55:0]          req_tdata,  // request_bytes[22:0], free_address[54:23], pad
   input  logic                 req_tuser,  // opcode
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [ADDR_W-1:0]    rsp_tdata,  // granted_address[31:0]
   output logic [STATUS_W-1:0]  rsp_tuser,  // status[1:0]
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   logic [POOL_W-1:0]   pool_ff;
   logic [ADDR_W-1:0]   base_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;

   cfg_type    cfg;
   item_type   item;
   result_type res;
   logic       clear_req;
   logic       res_valid;
   logic       res_ready;
   logic       csr_write;

   // Registers are always writable
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   // A new pool size invalidates every run: sweep the map again
   assign clear_req = csr_write && (csr_index == CSR_POOL_PAGES);

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= '0;
         base_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_POOL_PAGES:   pool_ff <= csr_data[POOL_W-1:0];
            CSR_BASE_ADDRESS: base_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.pool_pages   = pool_ff;
   assign cfg.base_address = base_ff;

   // Unpack the request transaction
   assign item.opcode        = req_tuser;
   assign item.request_bytes = req_tdata[BYTES_W-1:0];
   assign item.free_address  = req_tdata[BYTES_W+ADDR_W-1:BYTES_W];

   cpa_engine #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_SHIFT(PAGE_SHIFT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .clear_req (clear_req),
      .item_valid(req_tvalid),
      .item_ready(req_tready),
      .item      (item),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register: take a result when empty or draining this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid && res_ready) begin
         rsp_status_ff <= res.status;
         rsp_addr_ff   <= res.granted_address;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_addr_ff;

endmodule

// ===== dv/tb_contiguous_page_allocator.sv =====
`timescale 1ns / 1ps

module tb_contiguous_page_allocator;
   import cpa_pkg::*;

   localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT_DEF;
   localparam int unsigned BYTES_HIGH = 4194304;
   // Longest quiet stretch of a correct run is a full-pool scan followed by a
   // full-pool run write, plus a receiver stall.
   localparam int          STALL_LIMIT = 20000;
   localparam int          TAIL_CYCLES = 32;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [55:0]          req_tdata = '0;   // request_bytes[22:0], free_address[54:23], pad
   logic                 req_tuser = OP_ALLOC;   // opcode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ADDR_W-1:0]    rsp_tdata;        // granted_address[31:0]
   logic [STATUS_W-1:0]  rsp_tuser;        // status[1:0]
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POOL_PAGES;
   logic [ADDR_W-1:0]    csr_data = '0;

   // Shadow of the allocator: configuration as last written and the page map
   logic [POOL_W-1:0]    pool_shadow = '0;
   logic [ADDR_W-1:0]    base_shadow = '0;
   logic [ENTRY_W-1:0]   page_shadow [MAX_PAGES_DEF];

   result_type           pending_results [$];
   int                   mismatch_count = 0;
   bit                   idle_enable = 1'b1;

   contiguous_page_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (page_shadow[i]) page_shadow[i] = ENTRY_FREE;
   end

   // ---------------------------------------------------------------------
   // Page map prediction
   // ---------------------------------------------------------------------

   // Pools above the map size are clipped to the map size
   function automatic int unsigned live_page_count();
      return (pool_shadow > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(pool_shadow);
   endfunction

   // First fit, scanning start indices from the highest that fits down to 0
   function automatic result_type predict_allocate(input logic [BYTES_W-1:0] bytes);
      int unsigned n;
      int unsigned need;
      int          start;
      bit          run_free;
      result_type  r;
      n = live_page_count();
      need = (32'(bytes) + PAGE_BYTES - 1) >> PAGE_SHIFT_DEF;
      r.status = ST_ALLOC_FAIL;
      r.granted_address = '0;
      if (need == 0 || n == 0 || need > n) return r;
      for (start = int'(n - need); start >= 0; start--) begin
         run_free = 1'b1;
         for (int k = 0; k < int'(need) && run_free; k++)
            if (page_shadow[start + k] != ENTRY_FREE) run_free = 1'b0;
         if (run_free) begin
            page_shadow[start] = need[ENTRY_W-1:0];
            for (int k = 1; k < int'(need); k++) page_shadow[start + k] = ENTRY_CONT;
            r.status = ST_OK;
            r.granted_address = base_shadow + 32'(start << PAGE_SHIFT_DEF);
            return r;
         end
      end
      return r;
   endfunction

   // Release the run headed by the page that holds addr; anything else is rejected
   function automatic result_type predict_release(input logic [ADDR_W-1:0] addr);
      int unsigned       n;
      int unsigned       idx;
      int unsigned       len;
      logic [ADDR_W-1:0] offset;
      result_type        r;
      n = live_page_count();
      offset = addr - base_shadow;
      idx = offset >> PAGE_SHIFT_DEF;
      r.status = ST_BAD_FREE;
      r.granted_address = '0;
      if (idx >= n) return r;
      if (page_shadow[idx] == ENTRY_FREE || page_shadow[idx] == ENTRY_CONT) return r;
      len = 32'(page_shadow[idx]);
      for (int unsigned k = 0; k < len && idx + k < n; k++) page_shadow[idx + k] = ENTRY_FREE;
      r.status = ST_OK;
      return r;
   endfunction

   // Pick a live run head at random and name it by an address inside its page
   function automatic bit find_live_head(output logic [ADDR_W-1:0] addr);
      int unsigned n;
      int unsigned first;
      int unsigned idx;
      n = live_page_count();
      addr = '0;
      if (n == 0) return 1'b0;
      first = $urandom_range(0, n - 1);
      for (int unsigned k = 0; k < n; k++) begin
         idx = (first + k) % n;
         if (page_shadow[idx] != ENTRY_FREE && page_shadow[idx] != ENTRY_CONT) begin
            addr = base_shadow + 32'(idx << PAGE_SHIFT_DEF) + $urandom_range(0, PAGE_BYTES - 1);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------

   // Leave tvalid high after the transaction; the next call either replaces
   // the item in the same step or drops tvalid for a gap.
   task automatic send_request(input logic opcode, input logic [BYTES_W-1:0] bytes,
                               input logic [ADDR_W-1:0] addr);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= {1'b0, addr, bytes};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (opcode == OP_ALLOC) pending_results.push_back(predict_allocate(bytes));
      else pending_results.push_back(predict_release(addr));
   endtask

   // Unused field carries noise so that the block is seen to ignore it
   task automatic request_allocate(input int unsigned bytes);
      send_request(OP_ALLOC, BYTES_W'(bytes), $urandom);
   endtask

   task automatic request_release(input logic [ADDR_W-1:0] addr);
      logic [BYTES_W-1:0] noise;
      noise = BYTES_W'($urandom_range(0, BYTES_HIGH));
      send_request(OP_FREE, noise, addr);
   endtask

   // Drop the request valid in the step of the last transaction, then drain
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Pool size first (clears the map), base address in the following transaction
   task automatic configure_pool(input int unsigned pages, input logic [ADDR_W-1:0] base);
      csr_valid <= 1'b1;
      csr_index <= CSR_POOL_PAGES;
      csr_data  <= pages;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool_shadow = pages[POOL_W-1:0];
      foreach (page_shadow[i]) page_shadow[i] = ENTRY_FREE;
      csr_index <= CSR_BASE_ADDRESS;
      csr_data  <= base;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      base_shadow = base;
      csr_valid <= 1'b0;
   endtask

   // Receiver: stall in random bursts while idling is enabled
   initial begin
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare every result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d address %h", $time, rsp_tuser,
                     rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                        rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata !== want.granted_address) begin
               $display("%0t: address mismatch: expected %h actual %h", $time,
                        want.granted_address, rsp_tdata);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles without any transaction
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_contiguous_page_allocator: errors");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Out of reset there is no pool: every allocate fails, every free is rejected
   task automatic test_empty_pool();
      request_allocate(PAGE_BYTES);
      request_allocate('0);
      request_release('0);
      wait_for_results();
   endtask

   // Small pool: top-down first fit, rounding, bad frees and a full pool
   task automatic test_pool_boundaries();
      logic [ADDR_W-1:0] base;
      base = 32'h8000_0000;
      configure_pool(8, base);
      request_allocate(1);                        // single page at the top
      request_allocate(PAGE_BYTES);               // exact page, next one down
      request_allocate(PAGE_BYTES + 1);           // rounds up to two pages
      request_allocate('0);                       // zero bytes fails
      request_release(base + 32'h5000);           // continuation page
      request_release(base + 32'h4ABC);           // head named from inside its page
      request_release(base + 32'h4000);           // now a free page
      request_release(base - 32'h1000);           // below base wraps past the pool
      request_release(base + 32'h8000);           // first index past the pool
      request_allocate(8 * PAGE_BYTES + 1);       // larger than the pool
      request_allocate(BYTES_HIGH);               // largest request
      request_allocate(6 * PAGE_BYTES);           // fills the bottom of the pool
      request_allocate(1);                        // no room left
      request_release(base + 32'h7000);
      request_release(base + 32'h6FFF);           // last byte of a head page
      request_release(base);
      request_allocate(8 * PAGE_BYTES);           // whole pool
      wait_for_results();
   endtask

   // Base near the top of the address space: granted addresses wrap
   task automatic test_wrapping_base();
      configure_pool(4, 32'hFFFF_E000);
      request_allocate(1);                        // page 3 lands at 0x1000
      request_release(32'h0000_1000);
      request_release(32'hFFFF_DFFF);             // just below base
      wait_for_results();
   endtask

   // Pool size beyond the map is clipped to the map size
   task automatic test_oversized_pool();
      configure_pool(2047, '0);
      request_allocate(BYTES_HIGH);               // exactly the whole map
      request_allocate(1);
      request_release(32'(MAX_PAGES_DEF << PAGE_SHIFT_DEF));
      request_release('0);
      wait_for_results();
   endtask

   // Mostly well-formed allocate/free traffic against the live map, some noise
   task automatic run_traffic(input int items);
      int unsigned        n;
      int unsigned        max_run;
      int unsigned        pages;
      int unsigned        pick;
      logic [ADDR_W-1:0]  addr;
      int unsigned        bytes;
      repeat (items) begin
         n = live_page_count();
         max_run = n / 4 + 1;
         pick = $urandom_range(0, 99);
         if (pick >= 45 && pick < 85 && find_live_head(addr)) begin
            request_release(addr);
         end else if (pick < 85) begin
            // keep most runs short so that big pools stay quick to scan
            if ($urandom_range(0, 3) == 0 || max_run < 4) pages = $urandom_range(1, max_run);
            else pages = $urandom_range(1, 4);
            bytes = (pages - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
            request_allocate(bytes);
         end else if (pick < 88) begin
            request_allocate('0);
         end else if (pick < 93) begin
            bytes = $urandom_range(0, BYTES_HIGH);
            request_allocate(bytes);
         end else if (pick < 97) begin
            request_release($urandom);
         end else begin
            // any page in or just past the pool: free, continuation or head
            addr = base_shadow + 32'($urandom_range(0, n + 3) << PAGE_SHIFT_DEF) +
                   $urandom_range(0, PAGE_BYTES - 1);
            request_release(addr);
         end
      end
   endtask

   // Phases over several pool sizes and bases, rewritten while runs are live
   task automatic test_random_traffic();
      int unsigned       pages;
      int                items;
      logic [ADDR_W-1:0] base;
      for (int phase = 0; phase < 9; phase++) begin
         items = 120;
         case (phase)
            0: begin
               pages = 1;
               items = 60;
            end
            1: pages = $urandom_range(2, 16);
            2: pages = 32;
            3: begin
               pages = MAX_PAGES_DEF;
               items = 50;
            end
            4: pages = $urandom_range(17, 200);
            5: begin
               pages = 0;
               items = 20;
            end
            6: begin
               pages = 2047;
               items = 40;
            end
            7: pages = 64;
            default: begin
               pages = $urandom_range(MAX_PAGES_DEF + 1, 2046);
               items = 40;
            end
         endcase
         if (phase == 2) base = '0;
         else if (phase == 7) base = 32'hFFFF_FFFF;
         else if ($urandom_range(0, 1) == 0) base = $urandom & 32'hFFFF_F000;
         else base = $urandom;
         // some phases run with no idling at all
         idle_enable = ($urandom_range(0, 3) != 0);
         configure_pool(pages, base);
         run_traffic(items);
         wait_for_results();
      end
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_full_rate();
      idle_enable = 1'b0;
      configure_pool($urandom_range(24, 96), $urandom);
      run_traffic(200);
      wait_for_results();
   endtask

   task automatic finish_run();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb_contiguous_page_allocator: clean");
      else
         $display("tb_contiguous_page_allocator: errors");
      $finish;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_pool();
      test_pool_boundaries();
      test_wrapping_base();
      test_oversized_pool();
      test_random_traffic();
      test_full_rate();
      finish_run();
   end

endmodule
